[design/ltlp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltlp_pkg
// Shared types and constants of the linear probing lock table.
// ----------------------------------------------------------------------------
package ltlp_pkg;

  // The slot count must be a power of two so that the slot arithmetic wraps.
  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int PROBE_W = $clog2(SLOTS + 2);

  // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP) >> SHIFT.
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;
  localparam int          QUOT_W      = 28;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_LOOKUP  = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_RELEASED  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_HASH,
    FSM_ISSUE,
    FSM_PROBE,
    FSM_FLUSH
  } fsm_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] tbl_num;
    logic [30:0] tup_num;
    logic [7:0]  node_id;
    logic [1:0]  lock_mode;
    logic [30:0] lock_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  rel_node;
    logic [15:0] rel_table;
    logic [30:0] rel_index;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0]  node_id;
    logic [15:0] tbl_num;
    logic [30:0] tup_num;
    logic [1:0]  lock_mode;
    logic [30:0] lock_index;
  } entry_t;

  typedef struct packed {
    logic              clr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] rd_addr;
  } mem_ctl_t;

endpackage
`default_nettype wire

[design/ltlp_hash.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltlp_hash
// Home slot unit. The tuple is divided by ten through a registered reciprocal
// product; the next cycle forms the home slot from the remainder.
// ----------------------------------------------------------------------------
module ltlp_hash (
  input  wire logic                      clk,
  input  wire logic [7:0]                node_id,
  input  wire logic [15:0]               tbl_num,
  input  wire logic [30:0]               tup_num,
  output logic      [ltlp_pkg::SLOT_W-1:0] home
);

  localparam int HSUM_W = ltlp_pkg::SLOT_W + 5;

  logic [63:0]                 prod;
  logic [ltlp_pkg::QUOT_W-1:0] quot_r;
  logic [30:0]                 quot10;
  logic [3:0]                  rem;
  logic [11:0]                 node10;
  logic [19:0]                 table10;
  logic [HSUM_W-1:0]           hsum;

  assign prod = 64'(tup_num) * 64'(ltlp_pkg::DIV10_RECIP);

  always_ff @(posedge clk) begin
    quot_r <= prod[ltlp_pkg::DIV10_SHIFT +: ltlp_pkg::QUOT_W];
  end

  always_comb begin
    quot10  = 31'({quot_r, 3'b000}) + 31'({quot_r, 1'b0});
    rem     = 4'(tup_num - quot10);
    node10  = 12'(node_id) * 12'd10;
    table10 = 20'(tbl_num) * 20'd10;
    hsum    = HSUM_W'(node10 % ltlp_pkg::SLOTS) + HSUM_W'(table10 % ltlp_pkg::SLOTS)
              + HSUM_W'(rem);
    home    = ltlp_pkg::SLOT_W'(hsum % ltlp_pkg::SLOTS);
  end

endmodule
`default_nettype wire

[design/ltlp_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltlp_mem
// Slot store with one read and one write port and a registered read. A valid
// bit per slot makes an unwritten or cleared slot read as all zero.
// ----------------------------------------------------------------------------
module ltlp_mem (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ltlp_pkg::mem_ctl_t ctl,
  input  wire ltlp_pkg::entry_t   wr_data,
  output ltlp_pkg::entry_t        rd_data
);

  ltlp_pkg::entry_t          mem_r [ltlp_pkg::SLOTS];
  ltlp_pkg::entry_t          rd_q_r;
  logic [ltlp_pkg::SLOTS-1:0] vld_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[ctl.wr_addr] <= wr_data;
    end
    rd_q_r <= mem_r[ctl.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld_r[ctl.wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[ctl.rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
`default_nettype wire

[design/lock_table_linear_probe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lock_table_linear_probe
// Open-addressed lock table with linear probing over a 64-slot store.
// Insert and lookup pass the hash and issue states, then probe one slot per
// cycle through the store's read port, up to 65 slots. Release scans all 64
// slots and gives one result per occupied slot. Clear: result in the cycle
// after start; busy stays low. One request at a time; else busy is high
// until the request ends. Synchronous reset empties the table at once.
// ----------------------------------------------------------------------------
module lock_table_linear_probe (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire ltlp_pkg::in_t  in_data,
  output logic                out_valid,
  output ltlp_pkg::out_t      out_data
);

  localparam int SW = ltlp_pkg::SLOT_W;
  localparam int PW = ltlp_pkg::PROBE_W;

  ltlp_pkg::fsm_t     state_r, state_nxt;
  ltlp_pkg::in_t      req_r, req_nxt;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic [PW-1:0]      probes_r, probes_nxt;
  ltlp_pkg::entry_t   pend_r, pend_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic               out_valid_r, out_valid_nxt;
  ltlp_pkg::out_t     out_data_r, out_data_nxt;

  ltlp_pkg::mem_ctl_t mem_ctl;
  ltlp_pkg::entry_t   wr_data;
  ltlp_pkg::entry_t   rd_data;
  logic [SW-1:0]      home;
  logic [SW-1:0]      slot_inc;
  logic               accept;
  logic               occupied;
  logic               key_hit;

  ltlp_hash u_hash (
    .clk     (clk),
    .node_id (req_r.node_id),
    .tbl_num (req_r.tbl_num),
    .tup_num (req_r.tup_num),
    .home    (home)
  );

  ltlp_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != ltlp_pkg::FSM_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign slot_inc = (slot_r == SW'(ltlp_pkg::SLOTS - 1)) ? '0 : slot_r + 1'b1;
  assign occupied = (rd_data.tup_num != '0);
  assign key_hit  = (rd_data.node_id == req_r.node_id) &&
                    (rd_data.tbl_num == req_r.tbl_num) &&
                    (rd_data.tup_num == req_r.tup_num);

  assign wr_data = {req_r.node_id, req_r.tbl_num, req_r.tup_num,
                    req_r.lock_mode, req_r.lock_index};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ltlp_pkg::FSM_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    slot_r     <= slot_nxt;
    probes_r   <= probes_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    slot_nxt      = slot_r;
    probes_nxt    = probes_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    mem_ctl       = '0;
    mem_ctl.wr_addr = slot_r;
    mem_ctl.rd_addr = slot_inc;

    unique case (state_r)
      ltlp_pkg::FSM_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          unique case (ltlp_pkg::req_t'(in_data.req_type))
            ltlp_pkg::REQ_INSERT, ltlp_pkg::REQ_LOOKUP: begin
              state_nxt = ltlp_pkg::FSM_HASH;
            end
            ltlp_pkg::REQ_RELEASE: begin
              state_nxt = ltlp_pkg::FSM_ISSUE;
            end
            ltlp_pkg::REQ_CLEAR: begin
              mem_ctl.clr         = 1'b1;
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ltlp_pkg::ST_CLEARED;
              out_data_nxt.last   = 1'b1;
            end
            default: begin
              state_nxt = ltlp_pkg::FSM_IDLE;
            end
          endcase
        end
      end

      ltlp_pkg::FSM_HASH: begin
        state_nxt = ltlp_pkg::FSM_ISSUE;
      end

      ltlp_pkg::FSM_ISSUE: begin
        state_nxt    = ltlp_pkg::FSM_PROBE;
        pend_vld_nxt = 1'b0;
        if (req_r.req_type == ltlp_pkg::REQ_RELEASE) begin
          slot_nxt = '0;
        end else begin
          slot_nxt = home;
        end
        mem_ctl.rd_addr = slot_nxt;
        probes_nxt = (req_r.req_type == ltlp_pkg::REQ_INSERT) ? PW'(1) : '0;
      end

      ltlp_pkg::FSM_PROBE: begin
        slot_nxt   = slot_inc;
        probes_nxt = probes_r + 1'b1;
        priority case (ltlp_pkg::req_t'(req_r.req_type))
          ltlp_pkg::REQ_INSERT: begin
            if (!occupied) begin
              mem_ctl.wr_en       = 1'b1;
              state_nxt           = ltlp_pkg::FSM_IDLE;
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ltlp_pkg::ST_INSERTED;
              out_data_nxt.last   = 1'b1;
            end else if (probes_r > PW'(ltlp_pkg::SLOTS)) begin
              state_nxt           = ltlp_pkg::FSM_IDLE;
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ltlp_pkg::ST_FULL;
              out_data_nxt.last   = 1'b1;
            end else if (key_hit) begin
              state_nxt           = ltlp_pkg::FSM_IDLE;
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ltlp_pkg::ST_DUPLICATE;
              out_data_nxt.last   = 1'b1;
            end
          end
          ltlp_pkg::REQ_LOOKUP: begin
            if (!occupied || probes_r >= PW'(ltlp_pkg::SLOTS)) begin
              state_nxt           = ltlp_pkg::FSM_IDLE;
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ltlp_pkg::ST_NOT_FOUND;
              out_data_nxt.last   = 1'b1;
            end else if (key_hit && rd_data.lock_mode == req_r.lock_mode) begin
              state_nxt           = ltlp_pkg::FSM_IDLE;
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ltlp_pkg::ST_FOUND;
              out_data_nxt.last   = 1'b1;
            end
          end
          default: begin
            if (occupied) begin
              pend_nxt     = rd_data;
              pend_vld_nxt = 1'b1;
              if (pend_vld_r) begin
                out_valid_nxt          = 1'b1;
                out_data_nxt.status    = ltlp_pkg::ST_RELEASED;
                out_data_nxt.rel_node  = pend_r.node_id;
                out_data_nxt.rel_table = pend_r.tbl_num;
                out_data_nxt.rel_index = pend_r.lock_index;
              end
            end
            if (slot_r == SW'(ltlp_pkg::SLOTS - 1)) begin
              state_nxt = ltlp_pkg::FSM_FLUSH;
            end
          end
        endcase
      end

      ltlp_pkg::FSM_FLUSH: begin
        state_nxt    = ltlp_pkg::FSM_IDLE;
        pend_vld_nxt = 1'b0;
        if (pend_vld_r) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = ltlp_pkg::ST_RELEASED;
          out_data_nxt.rel_node  = pend_r.node_id;
          out_data_nxt.rel_table = pend_r.tbl_num;
          out_data_nxt.rel_index = pend_r.lock_index;
          out_data_nxt.last      = 1'b1;
        end
      end

      default: begin
        state_nxt = ltlp_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
